[src/composite_key_sorted_list_macros.svh]
// Assertion macros for the composite key sorted list checker
`ifndef COMPOSITE_KEY_SORTED_LIST_MACROS_SVH
`define COMPOSITE_KEY_SORTED_LIST_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define CKSL_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define CKSL_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[src/cksl_pkg.sv]
// Package: types, codes and key function for the composite key sorted list
`timescale 1ns / 1ps
package cksl_pkg;

	localparam int CAPACITY_DEF = 64;

	typedef enum logic [1:0] {
		CMD_INSERT = 2'd0,
		CMD_READ   = 2'd1,
		CMD_CLEAR  = 2'd2
	} cmd_t;

	typedef enum logic [2:0] {
		ST_STORED   = 3'd0,
		ST_FILTERED = 3'd1,
		ST_FULL     = 3'd2,
		ST_ENTRY    = 3'd3,
		ST_EMPTY    = 3'd4
	} status_t;

	typedef enum logic {
		S_IDLE,
		S_READ
	} state_t;

	typedef struct packed {
		cmd_t               command;
		logic [7:0]         rating;
		logic [23:0]        price_cents;
		logic signed [15:0] stock;
		logic [63:0]        name_key;
		logic [15:0]        tag;
	} req_t;

	typedef struct packed {
		status_t     status;
		logic [7:0]  out_rating;
		logic [23:0] out_price_cents;
		logic [14:0] out_stock;
		logic [63:0] out_name_key;
		logic [15:0] out_tag;
		logic        last;
	} rsp_t;

	typedef struct packed {
		logic [7:0]  rating;
		logic [23:0] price_cents;
		logic [14:0] stock;
		logic [63:0] name_key;
		logic [15:0] tag;
	} rec_t;

	typedef struct packed {
		logic insert;
		logic rotate;
	} cell_ctl_t;

	typedef logic [110:0] key_t;

	// larger key ranks first
	function automatic key_t sort_key(rec_t r);
		return {r.rating, ~r.price_cents, r.stock, r.name_key};
	endfunction

endpackage

[src/cksl_cell.sv]
// One list cell: holds a record, compares it with the incoming one, shifts or rotates
`timescale 1ns / 1ps
module cksl_cell #(
	parameter int IDX = 0,
	parameter int CW  = 7
) (
	input  logic               clk,
	input  cksl_pkg::cell_ctl_t ctl,
	input  logic [CW-1:0]      count,
	input  cksl_pkg::rec_t     new_rec,
	input  cksl_pkg::rec_t     left_rec,
	input  logic               left_place,
	input  cksl_pkg::rec_t     right_rec,
	input  cksl_pkg::rec_t     head_rec,
	output logic               place,
	output cksl_pkg::rec_t     rec
);
	import cksl_pkg::*;

	rec_t rec_q;
	logic occ;
	logic at_end;
	logic is_tail;
	logic ahead;

	assign occ     = CW'(IDX) < count;
	assign at_end  = count == CW'(IDX);
	assign is_tail = count == CW'(IDX + 1);
	assign ahead   = sort_key(new_rec) > sort_key(rec_q);
	assign place   = occ ? ahead : at_end;
	assign rec     = rec_q;

	always_ff @(posedge clk) begin
		if (ctl.insert && place) begin
			rec_q <= left_place ? left_rec : new_rec;
		end else if (ctl.rotate) begin
			rec_q <= is_tail ? head_rec : right_rec;
		end
	end

endmodule

[src/composite_key_sorted_list.sv]
// Top level: sorted record list built as a chain of compare-and-shift cells
//
// Request channel req (valid/ready) carries a command and one record.
// Response channel rsp (valid/ready) returns result beats from an output register.
// Insert: every cell compares its record with the new one in the same cycle and, for a
// stored record, the tail of the list shifts right by one cell; one beat (stored, filtered
// out or list full) is ready in the cycle after the request beat. Inserts, clears and empty
// read-outs are taken one per cycle while the receiver keeps up.
// Read out of N entries: the chain rotates toward cell 0 once per beat, giving N
// beats, one per cycle while the receiver keeps up, the first via S_READ and the
// output register; last marks the final beat. The list is back in place after the
// last beat. No request is taken until it is loaded into the output register.
// Clear: empties the list, no beat.
// Reset: list empty, no beat pending. Cell contents are not cleared.
// Receiver stall: the output register holds its beat; the chain stops rotating and
// req_ready stays low until the register frees up.
`timescale 1ns / 1ps
module composite_key_sorted_list #(
	parameter int CAPACITY = cksl_pkg::CAPACITY_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  cksl_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output cksl_pkg::rsp_t rsp
);
	import cksl_pkg::*;

	localparam int CW = $clog2(CAPACITY + 1);

	state_t        state_q;
	state_t        state_d;
	logic [CW-1:0] count_q;
	logic [CW-1:0] count_d;
	logic [CW-1:0] remain_q;
	logic [CW-1:0] remain_d;
	logic          rsp_valid_q;
	rsp_t          rsp_q;
	rsp_t          rsp_d;
	logic          load;
	logic          slot_free;
	logic          accept;
	logic          filtered;
	logic          full;
	cell_ctl_t     ctl;
	rec_t          new_rec;
	rec_t          cell_rec   [CAPACITY];
	logic          cell_place [CAPACITY];

	assign new_rec = '{
		rating:      req.rating,
		price_cents: req.price_cents,
		stock:       req.stock[14:0],
		name_key:    req.name_key,
		tag:         req.tag
	};

	assign slot_free = !rsp_valid_q || rsp_ready;
	assign accept    = req_valid && req_ready;
	assign filtered  = req.stock[15] || (req.stock == 16'sd0);
	assign full      = count_q == CW'(CAPACITY);

	genvar gi;
	generate
		for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
			rec_t left_rec;
			logic left_place;
			rec_t right_rec;
			if (gi == 0) begin : g_first
				assign left_rec   = new_rec;
				assign left_place = 1'b0;
			end else begin : g_mid
				assign left_rec   = cell_rec[gi-1];
				assign left_place = cell_place[gi-1];
			end
			if (gi == CAPACITY - 1) begin : g_last
				assign right_rec = cell_rec[gi];
			end else begin : g_inner
				assign right_rec = cell_rec[gi+1];
			end
			cksl_cell #(
				.IDX (gi),
				.CW  (CW)
			) u_cell (
				.clk        (clk),
				.ctl        (ctl),
				.count      (count_q),
				.new_rec    (new_rec),
				.left_rec   (left_rec),
				.left_place (left_place),
				.right_rec  (right_rec),
				.head_rec   (cell_rec[0]),
				.place      (cell_place[gi]),
				.rec        (cell_rec[gi])
			);
		end
	endgenerate

	always_comb begin
		state_d   = state_q;
		count_d   = count_q;
		remain_d  = remain_q;
		req_ready = 1'b0;
		load      = 1'b0;
		ctl       = '0;
		rsp_d     = '0;
		case (state_q)
			S_IDLE: begin
				req_ready = slot_free;
				if (accept) begin
					case (req.command)
						CMD_INSERT: begin
							load       = 1'b1;
							rsp_d.last = 1'b1;
							if (filtered) begin
								rsp_d.status = ST_FILTERED;
							end else if (full) begin
								rsp_d.status = ST_FULL;
							end else begin
								rsp_d.status = ST_STORED;
								ctl.insert   = 1'b1;
								count_d      = count_q + 1'b1;
							end
						end
						CMD_READ: begin
							if (count_q == '0) begin
								load         = 1'b1;
								rsp_d.status = ST_EMPTY;
								rsp_d.last   = 1'b1;
							end else begin
								state_d  = S_READ;
								remain_d = count_q;
							end
						end
						CMD_CLEAR: begin
							count_d = '0;
						end
						default: begin
						end
					endcase
				end
			end
			S_READ: begin
				if (slot_free) begin
					load                  = 1'b1;
					ctl.rotate            = 1'b1;
					rsp_d.status          = ST_ENTRY;
					rsp_d.out_rating      = cell_rec[0].rating;
					rsp_d.out_price_cents = cell_rec[0].price_cents;
					rsp_d.out_stock       = cell_rec[0].stock;
					rsp_d.out_name_key    = cell_rec[0].name_key;
					rsp_d.out_tag         = cell_rec[0].tag;
					rsp_d.last            = remain_q == CW'(1);
					remain_d              = remain_q - 1'b1;
					if (remain_q == CW'(1)) begin
						state_d = S_IDLE;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			remain_q    <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			count_q  <= count_d;
			remain_q <= remain_d;
			if (load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

[src/cksl_checker.sv]
// Port-level checker for the composite key sorted list, bound to the top level
`timescale 1ns / 1ps
`include "composite_key_sorted_list_macros.svh"
module cksl_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           req_valid,
	input logic           req_ready,
	input cksl_pkg::req_t req,
	input logic           rsp_valid,
	input logic           rsp_ready,
	input cksl_pkg::rsp_t rsp
);
	import cksl_pkg::*;

	`CKSL_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp), "response beat dropped or changed while stalled")
	`CKSL_ASSERT_NEXT(a_insert_answer, req_valid && req_ready && (req.command == CMD_INSERT), rsp_valid && rsp.last, "insert gave no single final beat")
	`CKSL_ASSERT_NOW(a_single_last, rsp_valid && (rsp.status != ST_ENTRY), rsp.last, "non-entry beat not marked last")
	`CKSL_ASSERT_NOW(a_readout_busy, rsp_valid && !rsp.last, !req_ready, "request taken during read out")

endmodule

bind composite_key_sorted_list cksl_checker u_cksl_checker (.*);

[test/composite_key_sorted_list_tb.sv]
// Testbench for the composite key sorted list: directed and random commands checked against a shadow list
`timescale 1ns / 1ps
module composite_key_sorted_list_tb;
	import cksl_pkg::*;

	localparam int DEPTH = CAPACITY_DEF;
	localparam int SETTLE = 8;
	localparam logic [1:0] CMD_UNDEF = 2'd3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;

	rec_t shadow_list[$];
	rsp_t expected_beats[$];
	int mismatch_count = 0;
	bit src_gaps = 1'b1;
	bit sink_stalls = 1'b1;
	int hold_off = 0;

	composite_key_sorted_list #(.CAPACITY(DEPTH)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp)
	);

	always #2 clk = ~clk;

	function automatic int idle_len();
		if ($urandom_range(0, 99) < 85)
			return $urandom_range(1, 3);
		return $urandom_range(10, 30);
	endfunction

	function automatic bit ranks_ahead(rec_t a, rec_t b);
		if (a.rating != b.rating)
			return a.rating > b.rating;
		if (a.price_cents != b.price_cents)
			return a.price_cents < b.price_cents;
		if (a.stock != b.stock)
			return a.stock > b.stock;
		return a.name_key > b.name_key;
	endfunction

	function automatic void predict_beats(req_t item);
		rsp_t beat;
		rec_t fresh;
		int slot;
		beat = '0;
		beat.last = 1'b1;
		case (item.command)
			CMD_INSERT: begin
				if (item.stock[15] || item.stock == 16'd0) begin
					beat.status = ST_FILTERED;
				end else if (shadow_list.size() >= DEPTH) begin
					beat.status = ST_FULL;
				end else begin
					fresh = '{item.rating, item.price_cents, item.stock[14:0],
						item.name_key, item.tag};
					slot = shadow_list.size();
					for (int i = 0; i < shadow_list.size(); i++) begin
						if (ranks_ahead(fresh, shadow_list[i])) begin
							slot = i;
							break;
						end
					end
					shadow_list.insert(slot, fresh);
					beat.status = ST_STORED;
				end
				expected_beats.push_back(beat);
			end
			CMD_READ: begin
				if (shadow_list.size() == 0) begin
					beat.status = ST_EMPTY;
					expected_beats.push_back(beat);
				end else begin
					foreach (shadow_list[i]) begin
						beat.status = ST_ENTRY;
						beat.out_rating = shadow_list[i].rating;
						beat.out_price_cents = shadow_list[i].price_cents;
						beat.out_stock = shadow_list[i].stock;
						beat.out_name_key = shadow_list[i].name_key;
						beat.out_tag = shadow_list[i].tag;
						beat.last = (i == shadow_list.size() - 1);
						expected_beats.push_back(beat);
					end
				end
			end
			CMD_CLEAR: shadow_list.delete();
			default: ;
		endcase
	endfunction

	function automatic req_t record_item(logic [7:0] rating, logic [23:0] price,
			logic [15:0] stock, logic [63:0] name_key, logic [15:0] tag);
		req_t item;
		item.command = CMD_INSERT;
		item.rating = rating;
		item.price_cents = price;
		item.stock = stock;
		item.name_key = name_key;
		item.tag = tag;
		return item;
	endfunction

	function automatic req_t command_item(logic [1:0] code);
		req_t item;
		item = record_item(8'($urandom), 24'($urandom), 16'($urandom),
			{$urandom, $urandom}, 16'($urandom));
		item.command = cmd_t'(code);
		return item;
	endfunction

	function automatic req_t random_insert();
		logic [7:0] rating;
		logic [23:0] price;
		logic [15:0] stock;
		logic [63:0] name_key;
		rating = ($urandom_range(0, 2) == 0) ? 8'($urandom) : 8'(100 + $urandom_range(0, 3));
		case ($urandom_range(0, 5))
			0: price = 24'hFFFFFF;
			1: price = 24'd0;
			2, 3: price = 24'($urandom);
			default: price = 24'($urandom_range(0, 3) * 1000);
		endcase
		case ($urandom_range(0, 5))
			0: stock = 16'd32767;
			1, 2: stock = 16'($urandom_range(1, 32767));
			default: stock = 16'($urandom_range(1, 3));
		endcase
		name_key = ($urandom_range(0, 1) == 0) ? {$urandom, $urandom}
			: {56'd0, 8'($urandom_range(0, 3))};
		return record_item(rating, price, stock, name_key, 16'($urandom));
	endfunction

	function automatic req_t filtered_insert();
		req_t item;
		item = random_insert();
		item.stock = 16'(-$urandom_range(0, 32768));
		return item;
	endfunction

	task automatic send_req(input req_t item);
		int gap;
		gap = (src_gaps && $urandom_range(0, 2) == 0) ? idle_len() : 0;
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req <= item;
		req_valid <= 1'b1;
		do @(posedge clk); while (!req_ready);
		predict_beats(item);
	endtask

	task automatic wait_drained();
		req_valid <= 1'b0;
		while (expected_beats.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic flag(string field, logic [63:0] want, logic [63:0] got);
		mismatch_count++;
		$display("%0t ns: %s expected %0h actual %0h", $time, field, want, got);
	endtask

	always @(posedge clk) begin : beat_checker
		rsp_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (expected_beats.size() == 0) begin
				mismatch_count++;
				$display("%0t ns: beat expected none actual status %0d tag %0h",
					$time, rsp.status, rsp.out_tag);
			end else begin
				want = expected_beats.pop_front();
				if (rsp.status !== want.status)
					flag("status", want.status, rsp.status);
				if (rsp.out_rating !== want.out_rating)
					flag("out_rating", want.out_rating, rsp.out_rating);
				if (rsp.out_price_cents !== want.out_price_cents)
					flag("out_price_cents", want.out_price_cents, rsp.out_price_cents);
				if (rsp.out_stock !== want.out_stock)
					flag("out_stock", want.out_stock, rsp.out_stock);
				if (rsp.out_name_key !== want.out_name_key)
					flag("out_name_key", want.out_name_key, rsp.out_name_key);
				if (rsp.out_tag !== want.out_tag)
					flag("out_tag", want.out_tag, rsp.out_tag);
				if (rsp.last !== want.last)
					flag("last", want.last, rsp.last);
			end
		end
	end

	initial begin : sink_pacing
		wait (arst_n === 1'b1);
		forever begin
			if (hold_off > 0) begin
				rsp_ready <= 1'b0;
				repeat (hold_off) @(posedge clk);
				hold_off = 0;
			end else if (sink_stalls && $urandom_range(0, 3) == 0) begin
				rsp_ready <= 1'b0;
				repeat (idle_len()) @(posedge clk);
			end else begin
				rsp_ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	task automatic test_empty_list();
		send_req(command_item(CMD_READ));
		send_req(record_item(8'd7, 24'd70, 16'd0, 64'h55, 16'h0001));
		send_req(record_item(8'd7, 24'd70, 16'hFFFF, 64'h55, 16'h0002));
		send_req(record_item(8'd7, 24'd70, 16'h8000, 64'h55, 16'h0003));
		send_req(command_item(CMD_UNDEF));
		send_req(command_item(CMD_CLEAR));
		send_req(command_item(CMD_READ));
		wait_drained();
	endtask

	task automatic test_key_order();
		send_req(record_item(8'd100, 24'd500, 16'd10, 64'h41, 16'h0001));
		send_req(record_item(8'd255, 24'd500, 16'd10, 64'h41, 16'h0002));
		send_req(record_item(8'd0, 24'd500, 16'd10, 64'h41, 16'h0003));
		send_req(record_item(8'd100, 24'd0, 16'd10, 64'h41, 16'h0004));
		send_req(record_item(8'd100, 24'hFFFFFF, 16'd10, 64'h41, 16'h0005));
		send_req(record_item(8'd100, 24'd500, 16'd32767, 64'h41, 16'h0006));
		send_req(record_item(8'd100, 24'd500, 16'd1, 64'h41, 16'h0007));
		send_req(record_item(8'd100, 24'd500, 16'd10, 64'hFFFFFFFFFFFFFFFF, 16'h0008));
		send_req(record_item(8'd100, 24'd500, 16'd10, 64'h0, 16'h0009));
		send_req(record_item(8'd100, 24'd500, 16'd10, 64'h41, 16'hFFFF));
		send_req(command_item(CMD_READ));
		send_req(command_item(CMD_CLEAR));
		send_req(command_item(CMD_READ));
		wait_drained();
	endtask

	task automatic test_fill_and_backpressure();
		src_gaps = 1'b0;
		hold_off = 300;
		repeat (DEPTH + 2) send_req(random_insert());
		src_gaps = 1'b1;
		send_req(command_item(CMD_READ));
		send_req(filtered_insert());
		wait_drained();
		send_req(command_item(CMD_CLEAR));
		send_req(command_item(CMD_READ));
		wait_drained();
	endtask

	task automatic test_random_mix();
		int pick;
		for (int i = 0; i < 230; i++) begin
			if (i % 50 == 0) begin
				src_gaps = ((i / 50) % 2 == 0);
				sink_stalls = ((i / 50) % 2 == 0);
			end
			pick = $urandom_range(0, 99);
			if (pick < 66)
				send_req(random_insert());
			else if (pick < 74)
				send_req(filtered_insert());
			else if (pick < 88)
				send_req(command_item(CMD_READ));
			else if (pick < 94)
				send_req(command_item(CMD_CLEAR));
			else
				send_req(command_item(CMD_UNDEF));
		end
		src_gaps = 1'b1;
		sink_stalls = 1'b1;
		send_req(command_item(CMD_READ));
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_list();
		test_key_order();
		test_fill_and_backpressure();
		test_random_mix();
		wait_drained();
		if (mismatch_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	initial begin
		#20000000;
		$display("FAIL");
		$finish;
	end

endmodule
